// ===== hw/rtl/aqi_pkg.sv =====
// Shared types, breakpoint tables and helpers for the air quality index pipeline.
// Used by aqi_round_div and aqi_piecewise_linear_index; no dependencies.
`timescale 1ns / 1ps

package aqi_pkg;

  localparam int ROWS     = 7;
  localparam int SEGMENTS = 7;
  localparam int SEG_N    = (SEGMENTS > ROWS) ? ROWS : SEGMENTS;
  localparam int TABLES   = 3;

  localparam int CONC_W  = 18;
  localparam int Q10_W   = 15;
  localparam int SEG_W   = 3;
  localparam int TAB_W   = 2;
  localparam int SPAN_W  = 7;
  localparam int IDX_W   = 9;
  localparam int NUM_W   = CONC_W + SPAN_W;
  localparam int X_W     = NUM_W + 1;
  localparam int DEN2_W  = 15;
  localparam int RECIP_W = 19;
  localparam int RECIP_SHIFT = 26;
  localparam int QUOT_W  = 19;
  localparam int VAL_W   = QUOT_W + 1;

  // Reciprocal of ten, exact floor for every 18-bit reading
  localparam int DIV10_SHIFT = 22;
  localparam logic [18:0] DIV10_RECIP = 19'd419431;

  localparam logic [11:0] INDEX_MAX    = 12'hfff;
  localparam int          BRIGHT_LIMIT = 127500;

  // Pollutant codes
  localparam logic [TAB_W-1:0] POL_PM25  = 2'd0;
  localparam logic [TAB_W-1:0] POL_PM10  = 2'd1;
  localparam logic [TAB_W-1:0] POL_CO2   = 2'd2;
  localparam logic [TAB_W-1:0] POL_SPARE = 2'd3;

  // Category codes
  localparam logic [2:0] CAT_GOOD      = 3'd0;
  localparam logic [2:0] CAT_VERY_HAZ  = 3'd6;

  typedef logic [CONC_W-1:0] conc_t;

  typedef struct packed {
    logic [1:0]        pollutant;
    logic [CONC_W-1:0] concentration;
  } reading_t;

  typedef struct packed {
    logic [11:0] index_value;
    logic        saturated;
    logic [2:0]  category;
    logic [23:0] category_color;
    logic        text_black;
  } result_t;

  // Concentration bounds in tenths, [table][row]
  localparam conc_t CONC_LO [TABLES][ROWS] = '{
    '{18'd0, 18'd121,  18'd355,   18'd555,   18'd1505,  18'd2505,  18'd3505},
    '{18'd0, 18'd550,  18'd1550,  18'd2550,  18'd3550,  18'd4250,  18'd5050},
    '{18'd0, 18'd7010, 18'd10010, 18'd15010, 18'd20010, 18'd30010, 18'd40010}};
  localparam conc_t CONC_HI [TABLES][ROWS] = '{
    '{18'd120,  18'd354,   18'd554,   18'd1504,  18'd2504,  18'd3504,  18'd5004},
    '{18'd540,  18'd1540,  18'd2540,  18'd3540,  18'd4240,  18'd5040,  18'd6040},
    '{18'd7000, 18'd10000, 18'd15000, 18'd20000, 18'd30000, 18'd40000, 18'd50000}};

  // Twice the segment width, the rounding divisor
  localparam logic [DEN2_W-1:0] DEN2 [TABLES][ROWS] = '{
    '{15'd240,   15'd466,  15'd398,  15'd1898, 15'd1998,  15'd1998,  15'd2998},
    '{15'd1080,  15'd1980, 15'd1980, 15'd1980, 15'd1380,  15'd1580,  15'd1980},
    '{15'd14000, 15'd5980, 15'd9980, 15'd9980, 15'd19980, 15'd19980, 15'd19980}};

  // ceil(2^RECIP_SHIFT / DEN2)
  localparam logic [RECIP_W-1:0] RECIP [TABLES][ROWS] = '{
    '{19'd279621, 19'd144011, 19'd168616, 19'd35358, 19'd33589, 19'd33589, 19'd22385},
    '{19'd62138,  19'd33894,  19'd33894,  19'd33894, 19'd48630, 19'd42474, 19'd33894},
    '{19'd4794,   19'd11223,  19'd6725,   19'd6725,  19'd3359,  19'd3359,  19'd3359}};

  localparam logic [IDX_W-1:0]  IDX_LO   [ROWS] = '{9'd0, 9'd51, 9'd101, 9'd151,
                                                    9'd201, 9'd301, 9'd401};
  localparam logic [SPAN_W-1:0] IDX_SPAN [ROWS] = '{7'd50, 7'd49, 7'd49, 7'd49,
                                                    7'd99, 7'd99, 7'd99};
  localparam logic [IDX_W-1:0]  IDX_HI   [ROWS] = '{9'd50, 9'd100, 9'd150, 9'd200,
                                                    9'd300, 9'd400, 9'd500};

  localparam logic [23:0] CAT_COLOR [ROWS] = '{
    24'h00e400, 24'hffff00, 24'hff7e00, 24'hff0000,
    24'h8f3f97, 24'h7e0023, 24'h7e0023};

  function automatic logic contrast_black(input logic [23:0] rgb);
    logic [19:0] br;
    br = 20'(rgb[23:16]) * 20'd299 + 20'(rgb[15:8]) * 20'd587 + 20'(rgb[7:0]) * 20'd114;
    return br > 20'(BRIGHT_LIMIT);
  endfunction

endpackage

// ===== hw/rtl/aqi_piecewise_linear_index.sv =====
// Air quality index by piecewise linear interpolation with exact round half up.
// Valid path: v1, v2, v3, divider v_est and out_valid, then done; one item per cycle.
// busy is always low: every stage advances each cycle and the receiver cannot stall.
// Reset (synchronous, rst high) clears all stage valid bits; payload is not reset.
// Depends on aqi_pkg and aqi_round_div.
`timescale 1ns / 1ps

module aqi_piecewise_linear_index (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  aqi_pkg::reading_t reading,
  output logic              done,
  output aqi_pkg::result_t  result
);
  import aqi_pkg::*;

  // stage 1: table select, divide by ten
  logic              v1;
  logic [TAB_W-1:0]  tab1;
  conc_t             conc1;
  logic [Q10_W-1:0]  q10_1;
  logic [36:0]       div10_prod;

  // stage 2: segment search, distance into segment
  logic              v2;
  logic [TAB_W-1:0]  tab2;
  logic [SEG_W-1:0]  seg2;
  conc_t             diff2;
  conc_t             c_eff;
  conc_t             seg_lo;
  logic [SEG_W-1:0]  seg_sel;

  // stage 3: rounding numerator
  logic              v3;
  logic [TAB_W-1:0]  tab3;
  logic [SEG_W-1:0]  seg3;
  logic [X_W-1:0]    x3;
  logic [NUM_W-1:0]  num;
  logic [DEN2_W-1:0] den2_2;

  // divider result
  logic              v5;
  logic [QUOT_W-1:0] q5;
  logic [SEG_W-1:0]  seg5;

  // output stage
  logic [VAL_W-1:0]  val;
  logic              sat;
  logic [11:0]       idx12;
  logic [2:0]        cat;

  assign busy = 1'b0;

  assign div10_prod = 37'(reading.concentration) * 37'(DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    tab1  <= (reading.pollutant == POL_SPARE) ? POL_CO2 : reading.pollutant;
    conc1 <= reading.concentration;
    q10_1 <= div10_prod[DIV10_SHIFT +: Q10_W];
  end

  // PM10 and CO2 drop the tenths digit
  always_comb begin
    if (tab1 == POL_PM25) begin
      c_eff = conc1;
    end else begin
      c_eff = (CONC_W'(q10_1) << 3) + (CONC_W'(q10_1) << 1);
    end
    seg_sel = SEG_W'(SEG_N - 1);
    for (int k = SEG_N - 2; k >= 0; k--) begin
      if (c_eff <= CONC_HI[tab1][k]) begin
        seg_sel = SEG_W'(k);
      end
    end
    seg_lo = CONC_LO[tab1][seg_sel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    tab2  <= tab1;
    seg2  <= seg_sel;
    diff2 <= (c_eff >= seg_lo) ? (c_eff - seg_lo) : '0;
  end

  // x = 2 * span * diff + width, divided later by 2 * width
  assign num    = NUM_W'(IDX_SPAN[seg2]) * NUM_W'(diff2);
  assign den2_2 = DEN2[tab2][seg2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    tab3 <= tab2;
    seg3 <= seg2;
    x3   <= {num, 1'b0} + X_W'(den2_2 >> 1);
  end

  aqi_round_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .dividend  (x3),
    .divisor   (DEN2[tab3][seg3]),
    .recip     (RECIP[tab3][seg3]),
    .seg_in    (seg3),
    .out_valid (v5),
    .quot      (q5),
    .seg_out   (seg5)
  );

  always_comb begin
    val   = VAL_W'(IDX_LO[seg5]) + VAL_W'(q5);
    sat   = val > VAL_W'(INDEX_MAX);
    idx12 = sat ? INDEX_MAX : val[11:0];
    cat   = CAT_VERY_HAZ;
    for (int k = ROWS - 1; k >= 0; k--) begin
      if (idx12 <= 12'(IDX_HI[k])) begin
        cat = 3'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
    result.index_value    <= idx12;
    result.saturated      <= sat;
    result.category       <= cat;
    result.category_color <= CAT_COLOR[cat];
    result.text_black     <= contrast_black(CAT_COLOR[cat]);
  end

`ifndef SYNTHESIS
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 6))
    else $error("result without a matching item");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    $past(start, 6) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) &&
    !$past(rst, 4) && !$past(rst, 5) && !$past(rst, 6) |-> done)
    else $error("accepted item produced no result");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |-> result.index_value == INDEX_MAX)
    else $error("saturated index not clamped");

  a_top_cat: assert property (@(posedge clk) disable iff (rst)
    done && (result.index_value > 12'd500) |-> result.category == CAT_VERY_HAZ)
    else $error("index above last bound not in last category");
`endif

endmodule

// ===== hw/rtl/aqi_round_div.sv =====
// Two-stage exact floor division by a table divisor using a reciprocal multiply
// and a one-step correction. Depends on aqi_pkg.
`timescale 1ns / 1ps

module aqi_round_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [aqi_pkg::X_W-1:0]     dividend,
  input  logic [aqi_pkg::DEN2_W-1:0]  divisor,
  input  logic [aqi_pkg::RECIP_W-1:0] recip,
  input  logic [aqi_pkg::SEG_W-1:0]   seg_in,
  output logic                        out_valid,
  output logic [aqi_pkg::QUOT_W-1:0]  quot,
  output logic [aqi_pkg::SEG_W-1:0]   seg_out
);
  import aqi_pkg::*;

  localparam int PROD_W  = X_W + RECIP_W;
  localparam int CHECK_W = QUOT_W + DEN2_W;

  logic                  v_est;
  logic [QUOT_W-1:0]     q_est;
  logic [X_W-1:0]        x_est;
  logic [DEN2_W-1:0]     d_est;
  logic [SEG_W-1:0]      seg_est;
  logic [PROD_W-1:0]     prod;
  logic [CHECK_W-1:0]    check;
  logic                  over;

  // Estimate is the true quotient or one above it
  assign prod = PROD_W'(dividend) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_est <= 1'b0;
    end else begin
      v_est <= in_valid;
    end
    q_est   <= prod[RECIP_SHIFT +: QUOT_W];
    x_est   <= dividend;
    d_est   <= divisor;
    seg_est <= seg_in;
  end

  assign check = CHECK_W'(q_est) * CHECK_W'(d_est);
  assign over  = check > CHECK_W'(x_est);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_est;
    end
    quot    <= q_est - QUOT_W'(over);
    seg_out <= seg_est;
  end

endmodule
